FILE: design/wsd_pkg.sv
// Shared types, constants and helpers for the websocket message deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

	localparam int FRAME_W = 64;	// frame length register width
	localparam int SEC_W   = 32;	// section length register width

	// status codes carried on results
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMASKED  = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

	// websocket length byte markers
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// message header byte positions
	localparam logic [3:0] HDR_MAGIC_END = 4'd4;
	localparam logic [3:0] HDR_TEXT_END  = 4'd8;
	localparam logic [3:0] HDR_LAST      = 4'd11;

	// front to back token: one deframed byte or an unmasked-frame error
	typedef struct packed {
		logic       err;
		logic [7:0] data;
	} tok_t;

	// one result as seen on the output ports
	typedef struct packed {
		logic [7:0]       out_byte;
		logic             has_data;
		logic             part;
		logic             eom;
		logic [SEC_W-1:0] blen;
		logic [1:0]       status;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h44;
			2'd1:    b = 8'h69;
			2'd2:    b = 8'h4D;
			default: b = 8'h45;
		endcase
		return b;
	endfunction

endpackage

FILE: design/websocket_message_deframer.sv
// Top level of the websocket message deframer.
// Depends on wsd_pkg, wsd_front, wsd_tok_queue and wsd_back.
//
// Byte-serial receive deframer. One link byte is taken per clock (push while
// full is low). With ws_enabled set (cfg_we strobe, write only while idle),
// masked client websocket frames are stripped: 7/16/64-bit lengths, a 4-byte
// key, payload XOR-unmasked with a key index restarting every frame. An
// unmasked frame is an error. The resulting stream, or the raw bytes with
// ws_enabled clear, is cut into messages: 12-byte header (magic "D","i","M",
// "E", big-endian text length, big-endian binary length), then the text and
// binary sections. Every payload byte gives one result tagged by part; an
// empty message gives a single marker with has_data low and end_of_message
// high. An error gives one result with non-zero status, after which input is
// still accepted but discarded until reset. Sustained rate is one byte per
// cycle while results are popped; an accepted byte is registered in the token
// queue by the front end, then in the result queue by the back end.
// Each side stalls independently: full depends only on the token queue, and
// the back end drains it whenever the two-entry result queue has room.
module websocket_message_deframer import wsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_we,
	input  logic             ws_enabled,
	// byte input
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	// results
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             has_data,
	output logic             part,
	output logic             end_of_message,
	output logic [SEC_W-1:0] binary_length,
	output logic [1:0]       status
);

	logic ws_enabled_q;
	logic in_valid;
	logic tok_push;
	tok_t tok_in;
	logic tok_valid;
	logic tok_pop;
	tok_t tok_out;
	res_t res;

	// mode register; frame parser state survives mode changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_enabled_q <= 1'b0;
		end else if (cfg_we) begin
			ws_enabled_q <= ws_enabled;
		end
	end

	assign in_valid = push && !full;

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.ws_enabled (ws_enabled_q),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.tok_push   (tok_push),
		.tok        (tok_in)
	);

	// decouples frame parsing from message parsing
	wsd_tok_queue u_tok_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.din    (tok_in),
		.full   (full),
		.pop    (tok_pop),
		.valid  (tok_valid),
		.dout   (tok_out)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok_out),
		.tok_pop   (tok_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign out_byte       = res.out_byte;
	assign has_data       = res.has_data;
	assign part           = res.part;
	assign end_of_message = res.eom;
	assign binary_length  = res.blen;
	assign status         = res.status;

endmodule

FILE: design/wsd_front.sv
// Front end: websocket frame header parser and payload unmasker.
// Depends on wsd_pkg; feeds tokens into wsd_tok_queue.
module wsd_front import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ws_enabled,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       tok_push,
	output tok_t       tok
);

	typedef enum logic [2:0] {
		FP_FIRST,
		FP_LEN,
		FP_EXT,
		FP_KEY,
		FP_PAY
	} fphase_t;

	fphase_t            phase_q;
	logic [3:0]         hcnt_q;
	logic [FRAME_W-1:0] rem_q;
	logic [31:0]        key_q;
	logic [1:0]         idx_q;
	logic               err_q;

	logic [7:0]  key_byte;
	logic [7:0]  plain;
	logic [3:0]  hcnt_dec;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		plain    = in_byte ^ key_byte;
		hcnt_dec = hcnt_q - 4'd1;

		tok_push = 1'b0;
		tok.err  = 1'b0;
		tok.data = in_byte;
		if (in_valid && !err_q) begin
			if (!ws_enabled) begin
				tok_push = 1'b1;
			end else if (phase_q == FP_LEN && !in_byte[7]) begin
				// unmasked client frame
				tok_push = 1'b1;
				tok.err  = 1'b1;
				tok.data = 8'h00;
			end else if (phase_q == FP_PAY) begin
				tok_push = 1'b1;
				tok.data = plain;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= FP_FIRST;
			hcnt_q  <= '0;
			rem_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
			err_q   <= 1'b0;
		end else if (in_valid && !err_q && ws_enabled) begin
			case (phase_q)
				FP_FIRST: begin
					phase_q <= FP_LEN;
				end
				FP_LEN: begin
					if (!in_byte[7]) begin
						err_q <= 1'b1;
					end else if (in_byte[6:0] != LEN_EXT16 && in_byte[6:0] != LEN_EXT64) begin
						rem_q   <= {{(FRAME_W-7){1'b0}}, in_byte[6:0]};
						phase_q <= FP_KEY;
						hcnt_q  <= 4'd4;
					end else begin
						rem_q   <= '0;
						phase_q <= FP_EXT;
						hcnt_q  <= (in_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
					end
				end
				FP_EXT: begin
					rem_q  <= {rem_q[FRAME_W-9:0], in_byte};
					hcnt_q <= hcnt_dec;
					if (hcnt_dec == 4'd0) begin
						phase_q <= FP_KEY;
						hcnt_q  <= 4'd4;
					end
				end
				FP_KEY: begin
					key_q  <= {key_q[23:0], in_byte};
					hcnt_q <= hcnt_dec;
					if (hcnt_dec == 4'd0) begin
						idx_q   <= '0;
						phase_q <= (rem_q == '0) ? FP_FIRST : FP_PAY;
					end
				end
				FP_PAY: begin
					idx_q <= idx_q + 2'd1;
					rem_q <= rem_q - {{(FRAME_W-1){1'b0}}, 1'b1};
					if (rem_q == {{(FRAME_W-1){1'b0}}, 1'b1}) begin
						phase_q <= FP_FIRST;
						idx_q   <= '0;
					end
				end
				default: phase_q <= FP_FIRST;
			endcase
		end
	end

endmodule

FILE: design/wsd_tok_queue.sv
// Two-entry token queue between the frame front end and the message back end.
// Depends on wsd_pkg for the token type.
module wsd_tok_queue import wsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t din,
	output logic full,
	input  logic pop,
	output logic valid,
	output tok_t dout
);

	tok_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				mem_q[wp_q] <= din;
				wp_q        <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: design/wsd_back.sv
// Back end: message header parser, section tagging and two-entry result queue.
// Depends on wsd_pkg; takes tokens from wsd_tok_queue.
module wsd_back import wsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  tok_t tok,
	output logic tok_pop,
	input  logic pop,
	output logic empty,
	output res_t res
);

	typedef enum logic [1:0] {
		MP_HDR,
		MP_TEXT,
		MP_BIN
	} mphase_t;

	mphase_t          phase_q;
	logic [3:0]       hcnt_q;
	logic [SEC_W-1:0] text_q;
	logic [SEC_W-1:0] bin_q;
	logic             err_q;

	res_t       oq_q [2];
	logic       owp_q;
	logic       orp_q;
	logic [1:0] ocnt_q;

	logic             work;
	logic             deq;
	logic             bad_magic;
	logic [SEC_W-1:0] text_new;
	logic [SEC_W-1:0] bin_new;
	logic [SEC_W-1:0] text_dec;
	logic             res_valid;
	res_t             res_d;

	assign tok_pop = tok_valid && (ocnt_q != 2'd2);
	assign work    = tok_pop && !err_q;
	assign empty   = (ocnt_q == 2'd0);
	assign deq     = pop && !empty;
	assign res     = oq_q[orp_q];

	always_comb begin
		bad_magic = (hcnt_q < HDR_MAGIC_END) && (tok.data != magic_byte(hcnt_q[1:0]));
		// lengths keep their low SEC_W bits
		text_new  = (hcnt_q >= HDR_MAGIC_END && hcnt_q < HDR_TEXT_END) ?
			SEC_W'({text_q, tok.data}) : text_q;
		bin_new   = (hcnt_q >= HDR_TEXT_END) ? SEC_W'({bin_q, tok.data}) : bin_q;
		text_dec  = text_q - {{(SEC_W-1){1'b0}}, 1'b1};

		res_valid = 1'b0;
		res_d     = '0;
		if (work) begin
			if (tok.err) begin
				res_valid    = 1'b1;
				res_d.status = ST_UNMASKED;
			end else begin
				case (phase_q)
					MP_HDR: begin
						if (bad_magic) begin
							res_valid    = 1'b1;
							res_d.status = ST_BAD_MAGIC;
						end else if (hcnt_q == HDR_LAST && text_new == '0 && bin_new == '0) begin
							res_valid = 1'b1;	// empty message marker
							res_d.eom = 1'b1;
						end
					end
					MP_TEXT, MP_BIN: begin
						res_valid      = 1'b1;
						res_d.out_byte = tok.data;
						res_d.has_data = 1'b1;
						res_d.part     = (phase_q == MP_BIN);
						res_d.blen     = bin_q;
						res_d.eom      = (text_dec == '0) && !(phase_q == MP_TEXT && bin_q != '0);
					end
					default: res_valid = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_HDR;
			hcnt_q  <= '0;
			text_q  <= '0;
			bin_q   <= '0;
			err_q   <= 1'b0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= '0;
		end else begin
			if (work) begin
				if (tok.err) begin
					err_q <= 1'b1;
				end else begin
					case (phase_q)
						MP_HDR: begin
							if (bad_magic) begin
								err_q <= 1'b1;
							end else begin
								text_q <= text_new;
								bin_q  <= bin_new;
								if (hcnt_q == HDR_LAST) begin
									hcnt_q <= '0;
									if (text_new != '0) begin
										phase_q <= MP_TEXT;
									end else if (bin_new != '0) begin
										phase_q <= MP_BIN;
										text_q  <= bin_new;
									end
								end else begin
									hcnt_q <= hcnt_q + 4'd1;
								end
							end
						end
						MP_TEXT, MP_BIN: begin
							text_q <= text_dec;
							if (text_dec == '0) begin
								if (phase_q == MP_TEXT && bin_q != '0) begin
									phase_q <= MP_BIN;
									text_q  <= bin_q;
								end else begin
									phase_q <= MP_HDR;
									bin_q   <= '0;
								end
							end
						end
						default: phase_q <= MP_HDR;
					endcase
				end
			end

			if (res_valid) begin
				oq_q[owp_q] <= res_d;
				owp_q       <= ~owp_q;
			end
			if (deq) begin
				orp_q <= ~orp_q;
			end
			ocnt_q <= ocnt_q + {1'b0, res_valid} - {1'b0, deq};
		end
	end

endmodule

FILE: design/wsd_checker.sv
// Port-level checks for the websocket message deframer, bound to the top level.
// Depends on wsd_pkg for widths and status codes.
module wsd_checker import wsd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [7:0]       out_byte,
	input logic             has_data,
	input logic             part,
	input logic             end_of_message,
	input logic [SEC_W-1:0] binary_length,
	input logic [1:0]       status
);

	// data results are always ok
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && has_data |-> status == ST_OK)
		else $error("data result with error status");

	// an ok result without data is the empty message marker
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !has_data && status == ST_OK |-> end_of_message && binary_length == '0)
		else $error("bad empty message marker");

	// error results carry nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != ST_OK |->
			out_byte == 8'h00 && !part && !end_of_message && binary_length == '0)
		else $error("error result with payload");

	// an error is the last result until reset
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && status != ST_OK |=> empty)
		else $error("result after an error");

endmodule

bind websocket_message_deframer wsd_checker u_wsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.out_byte       (out_byte),
	.has_data       (has_data),
	.part           (part),
	.end_of_message (end_of_message),
	.binary_length  (binary_length),
	.status         (status)
);
